// ----- hw/rtl/dts_pkg.sv -----
`default_nettype none

package dts_pkg;

    localparam int TW_W         = 31;
    localparam int LEVEL_W      = 16;
    localparam int HEAD_W       = 17;
    localparam int MAG_W        = 16;
    localparam int PCM_W        = 16;
    localparam int PEAK_RAW_W   = 16;
    localparam int PEAK_CLAMP_W = 15;
    localparam int OUT_COUNT_W  = 48;

    localparam int HL_W = HEAD_W + LEVEL_W;
    localparam int M_W  = HL_W + MAG_W;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [HEAD_W-1:0]       HEADROOM_RESET = HEAD_W'(65536);
    localparam logic [M_W-1:0]          ONE_Q45        = M_W'(64'd1 << 45);
    localparam logic [M_W:0]            PEAK_HALF      = (M_W+1)'(64'd1 << 30);
    localparam logic [PEAK_CLAMP_W-1:0] ONE_Q14        = PEAK_CLAMP_W'(16384);
    localparam logic [PCM_W-1:0]        PCM_POS_FULL   = 16'h7FFF;
    localparam logic [PCM_W-1:0]        PCM_NEG_FULL   = 16'h8000;
    localparam logic [63:0]             HALF_PI_Q30    = 64'd1686629713;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_SCALE,
        BK_COMMIT
    } bk_state_t;

    typedef struct packed {
        logic [MAG_W-1:0]   mag;
        logic               neg;
        logic [LEVEL_W-1:0] level;
        logic               err;
        logic               clr;
    } dts_job_t;

    // Taylor term divisor (2n)(2n+1), elaboration only
    function automatic logic [63:0] taylor_div(input logic [63:0] v, input int n);
        logic [63:0] q;
        case (n)
            1:       q = v / 64'd6;
            2:       q = v / 64'd20;
            3:       q = v / 64'd42;
            4:       q = v / 64'd72;
            5:       q = v / 64'd110;
            6:       q = v / 64'd156;
            7:       q = v / 64'd210;
            default: q = v / 64'd272;
        endcase
        return q;
    endfunction

    // Quarter-wave entry k in Q1.15, qbits = log2 of quarter length
    function automatic logic [MAG_W-1:0] sine_entry(input logic [63:0] k, input int qbits);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        r;
        x    = (HALF_PI_Q30 * k + (64'd1 << (qbits - 1))) >> qbits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        for (int n = 1; n <= 8; n++) begin
            term = taylor_div((term * x2) >> 30, n);
            if ((n & 1) == 1)
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
        end
        if (sum < 0)
            sum = '0;
        r = ($unsigned(sum) + (64'd1 << 14)) >> 15;
        if (r > 64'd32768)
            r = 64'd32768;
        return r[MAG_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/dts_ifs.sv -----
`default_nettype none

interface dts_in_if import dts_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [TW_W-1:0]    tuning_word;
    logic [LEVEL_W-1:0] level;
    logic               restart;
    logic               clear_metrics;

    modport source (output valid, tuning_word, level, restart, clear_metrics, input ready);
    modport sink   (input valid, tuning_word, level, restart, clear_metrics, output ready);
endinterface

interface dts_out_if import dts_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [PCM_W-1:0] pcm_sample;
    logic                    clipped;
    logic                    tone_error;
    logic [PEAK_RAW_W-1:0]   peak_before_clamp;
    logic [PEAK_CLAMP_W-1:0] peak_after_clamp;
    logic [OUT_COUNT_W-1:0]  clipped_total;
    logic [OUT_COUNT_W-1:0]  samples_total;

    modport source (output valid, pcm_sample, clipped, tone_error, peak_before_clamp,
                    peak_after_clamp, clipped_total, samples_total, input ready);
    modport sink   (input valid, pcm_sample, clipped, tone_error, peak_before_clamp,
                    peak_after_clamp, clipped_total, samples_total, output ready);
endinterface

interface dts_cfg_if import dts_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [HEAD_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/dts_front.sv -----
`default_nettype none

module dts_front import dts_pkg::*; #(
    parameter int PHASE_BITS     = 32,
    parameter int SINE_ADDR_BITS = 10
) (
    input  wire logic clk,
    input  wire logic rst_n,
    dts_in_if.sink    req,
    input  wire logic full,
    output logic      push,
    output dts_job_t  job
);

    localparam int QBITS       = SINE_ADDR_BITS - 2;
    localparam int TIDX_W      = SINE_ADDR_BITS - 1;
    localparam int QUARTER_LEN = 1 << QBITS;

    logic [MAG_W-1:0] sine_rom [QUARTER_LEN+1];

    for (genvar k = 0; k <= QUARTER_LEN; k++) begin : g_rom
        localparam logic [MAG_W-1:0] ENTRY = sine_entry(64'(k), QBITS);
        assign sine_rom[k] = ENTRY;
    end

    logic [PHASE_BITS-1:0]     phase_reg;
    logic [PHASE_BITS-1:0]     phase_next;
    logic [PHASE_BITS-1:0]     phase_base;
    logic [PHASE_BITS-1:0]     tw_ext;
    logic [SINE_ADDR_BITS-1:0] idx;
    logic [1:0]                quad;
    logic [QBITS-1:0]          qi;
    logic [TIDX_W-1:0]         tidx;

    assign req.ready  = !full;
    assign push       = req.valid && !full;
    assign tw_ext     = PHASE_BITS'(req.tuning_word);
    assign phase_base = req.restart ? '0 : phase_reg;
    assign idx        = phase_base[PHASE_BITS-1 -: SINE_ADDR_BITS];
    assign quad       = idx[SINE_ADDR_BITS-1 -: 2];
    assign qi         = idx[QBITS-1:0];
    assign tidx       = quad[0] ? (TIDX_W'(QUARTER_LEN) - {1'b0, qi}) : {1'b0, qi};

    always_comb
    begin
        job.mag   = sine_rom[tidx];
        job.neg   = quad[1];
        job.level = req.level;
        job.err   = (req.tuning_word == '0);
        job.clr   = req.restart || req.clear_metrics;
    end

    always_comb
    begin
        phase_next = phase_reg;
        if (push)
            phase_next = job.err ? phase_base : phase_base + tw_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= '0;
        else
            phase_reg <= phase_next;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/dts_queue.sv -----
`default_nettype none

module dts_queue import dts_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire dts_job_t  wr_job,
    output logic           full,
    input  wire logic      pop,
    output dts_job_t       rd_job,
    output logic           empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    dts_job_t         slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_job  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= wr_job;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/dts_back.sv -----
`default_nettype none

module dts_back import dts_pkg::*; #(
    parameter int COUNT_BITS = 48
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    dts_cfg_if.sink       cfg,
    input  wire dts_job_t job,
    input  wire logic     empty,
    output logic          pop,
    dts_out_if.source     rsp
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    bk_state_t state_reg;
    bk_state_t state_next;

    logic [HEAD_W-1:0] headroom_reg;
    logic [HEAD_W-1:0] headroom_next;

    dts_job_t                job_reg;
    logic [HL_W-1:0]         hl_reg;
    logic [M_W-1:0]          m_reg;
    logic [PCM_W-1:0]        pcm_reg;
    logic                    clip_reg;
    logic [PEAK_RAW_W-1:0]   pr_reg;
    logic [PEAK_CLAMP_W-1:0] pc_reg;

    logic [PEAK_RAW_W-1:0]   peak_raw_reg,     peak_raw_next,     raw_base;
    logic [PEAK_CLAMP_W-1:0] peak_clamped_reg, peak_clamped_next, clamped_base;
    logic [COUNT_BITS-1:0]   clip_count_reg,   clip_count_next,   clip_base;
    logic [COUNT_BITS-1:0]   sample_count_reg, sample_count_next, sample_base;

    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [PCM_W-1:0]        out_pcm_reg;
    logic                    out_clip_reg;
    logic                    out_err_reg;
    logic [PEAK_RAW_W-1:0]   out_pr_reg;
    logic [PEAK_CLAMP_W-1:0] out_pc_reg;
    logic [OUT_COUNT_W-1:0]  out_clip_cnt_reg;
    logic [OUT_COUNT_W-1:0]  out_samp_cnt_reg;
    logic [OUT_COUNT_W-1:0]  clip_cnt_ext;
    logic [OUT_COUNT_W-1:0]  samp_cnt_ext;

    logic out_free;
    logic mul_en;
    logic scale_en;
    logic commit;

    // scale stage
    logic                    over;
    logic                    sat;
    logic [M_W:0]            pr_sum;
    logic [M_W-1:0]          mc;
    logic [M_W:0]            pc_sum;
    logic [44:0]             m45;
    logic [59:0]             scaled;
    logic [60:0]             rounded;
    logic [PCM_W-1:0]        mag;
    logic [PEAK_RAW_W-1:0]   pr_val;
    logic [PCM_W-1:0]        pcm_val;

    assign cfg.ready     = 1'b1;
    assign headroom_next = cfg.valid ? cfg.data : headroom_reg;
    assign out_free      = !out_valid_reg || rsp.ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:   if (!empty) state_next = BK_MUL;
            BK_MUL:    state_next = BK_SCALE;
            BK_SCALE:  state_next = BK_COMMIT;
            BK_COMMIT: if (out_free) state_next = BK_IDLE;
            default:   state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        pop      = 1'b0;
        mul_en   = 1'b0;
        scale_en = 1'b0;
        commit   = 1'b0;
        unique case (state_reg)
            BK_IDLE:   pop = !empty;
            BK_MUL:    mul_en = 1'b1;
            BK_SCALE:  scale_en = 1'b1;
            BK_COMMIT: commit = out_free;
            default:   pop = 1'b0;
        endcase
    end

    always_comb
    begin
        over    = (m_reg > ONE_Q45);
        sat     = (m_reg >= ONE_Q45);
        pr_sum  = {1'b0, m_reg} + PEAK_HALF;
        pr_val  = (|pr_sum[M_W:47]) ? '1 : pr_sum[46:31];
        mc      = over ? ONE_Q45 : m_reg;
        pc_sum  = {1'b0, mc} + PEAK_HALF;
        m45     = m_reg[44:0];
        scaled  = {m45, 15'd0} - {15'd0, m45};
        rounded = {1'b0, scaled} + (61'd1 << 44);
        mag     = rounded[60:45];
        if (sat)
            pcm_val = job_reg.neg ? PCM_NEG_FULL : PCM_POS_FULL;
        else
            pcm_val = job_reg.neg ? (PCM_W'(0) - mag) : mag;
    end

    always_comb
    begin
        raw_base          = job_reg.clr ? '0 : peak_raw_reg;
        clamped_base      = job_reg.clr ? '0 : peak_clamped_reg;
        clip_base         = job_reg.clr ? '0 : clip_count_reg;
        sample_base       = job_reg.clr ? '0 : sample_count_reg;
        peak_raw_next     = peak_raw_reg;
        peak_clamped_next = peak_clamped_reg;
        clip_count_next   = clip_count_reg;
        sample_count_next = sample_count_reg;
        if (commit)
        begin
            peak_raw_next     = raw_base;
            peak_clamped_next = clamped_base;
            clip_count_next   = clip_base;
            sample_count_next = sample_base;
            if (!job_reg.err)
            begin
                if (pr_reg > raw_base)
                    peak_raw_next = pr_reg;
                if (pc_reg > clamped_base)
                    peak_clamped_next = pc_reg;
                if (clip_reg && clip_base != COUNT_MAX)
                    clip_count_next = clip_base + COUNT_BITS'(1);
                if (sample_base != COUNT_MAX)
                    sample_count_next = sample_base + COUNT_BITS'(1);
            end
        end
    end

    if (COUNT_BITS >= OUT_COUNT_W) begin : g_cnt_trunc
        assign clip_cnt_ext = clip_count_next[OUT_COUNT_W-1:0];
        assign samp_cnt_ext = sample_count_next[OUT_COUNT_W-1:0];
    end
    else begin : g_cnt_ext
        assign clip_cnt_ext = {{(OUT_COUNT_W-COUNT_BITS){1'b0}}, clip_count_next};
        assign samp_cnt_ext = {{(OUT_COUNT_W-COUNT_BITS){1'b0}}, sample_count_next};
    end

    assign out_valid_next = commit ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= BK_IDLE;
            headroom_reg     <= HEADROOM_RESET;
            peak_raw_reg     <= '0;
            peak_clamped_reg <= '0;
            clip_count_reg   <= '0;
            sample_count_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            headroom_reg     <= headroom_next;
            peak_raw_reg     <= peak_raw_next;
            peak_clamped_reg <= peak_clamped_next;
            clip_count_reg   <= clip_count_next;
            sample_count_reg <= sample_count_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= job;
            hl_reg  <= headroom_reg * job.level;
        end
        if (mul_en)
            m_reg <= hl_reg * job_reg.mag;
        if (scale_en)
        begin
            pcm_reg  <= pcm_val;
            clip_reg <= over;
            pr_reg   <= pr_val;
            pc_reg   <= pc_sum[45:31];
        end
        if (commit)
        begin
            out_pcm_reg      <= job_reg.err ? '0 : pcm_reg;
            out_clip_reg     <= !job_reg.err && clip_reg;
            out_err_reg      <= job_reg.err;
            out_pr_reg       <= peak_raw_next;
            out_pc_reg       <= peak_clamped_next;
            out_clip_cnt_reg <= clip_cnt_ext;
            out_samp_cnt_reg <= samp_cnt_ext;
        end
    end

    assign rsp.valid             = out_valid_reg;
    assign rsp.pcm_sample        = $signed(out_pcm_reg);
    assign rsp.clipped           = out_clip_reg;
    assign rsp.tone_error        = out_err_reg;
    assign rsp.peak_before_clamp = out_pr_reg;
    assign rsp.peak_after_clamp  = out_pc_reg;
    assign rsp.clipped_total     = out_clip_cnt_reg;
    assign rsp.samples_total     = out_samp_cnt_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/dds_tone_sample_generator_unit.sv -----
// DDS tone generator: one signed 16-bit sample per transaction on sample_req, in order, on
// sample_rsp. The front end advances the phase accumulator and reads the quarter-wave table
// in the cycle a transaction is accepted, then parks the job in a two-entry queue. The back
// end sequencer takes one job at a time through four steps (headroom times level, times sine
// magnitude, scale and round, commit of metrics and result); the commit step waits while the
// output register still holds a result that the receiver has not yet taken from sample_rsp.
// The output register lets a new job start while the previous result waits. The sine table
// is built at elaboration. Write headroom on cfg only while no sample is in flight.
`default_nettype none

module dds_tone_sample_generator_unit import dts_pkg::*; #(
    parameter int PHASE_BITS     = 32,
    parameter int SINE_ADDR_BITS = 10,
    parameter int COUNT_BITS     = 48
) (
    input  wire logic clk,
    input  wire logic rst_n,
    dts_cfg_if.sink   cfg,
    dts_in_if.sink    sample_req,
    dts_out_if.source sample_rsp
);

    dts_job_t push_job;
    dts_job_t pop_job;
    logic     push;
    logic     pop;
    logic     full;
    logic     empty;

    dts_front #(
        .PHASE_BITS     (PHASE_BITS),
        .SINE_ADDR_BITS (SINE_ADDR_BITS)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sample_req),
        .full  (full),
        .push  (push),
        .job   (push_job)
    );

    dts_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (push_job),
        .full   (full),
        .pop    (pop),
        .rd_job (pop_job),
        .empty  (empty)
    );

    dts_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .job   (pop_job),
        .empty (empty),
        .pop   (pop),
        .rsp   (sample_rsp)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/dts_checker.sv -----
`default_nettype none

module dts_checker import dts_pkg::*; (
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    out_valid,
    input wire logic                    out_ready,
    input wire logic [PCM_W-1:0]        pcm_sample,
    input wire logic                    clipped,
    input wire logic                    tone_error,
    input wire logic [PEAK_RAW_W-1:0]   peak_before_clamp,
    input wire logic [PEAK_CLAMP_W-1:0] peak_after_clamp,
    input wire logic [OUT_COUNT_W-1:0]  samples_total
);

    // error transaction carries a silent, unclipped sample
    a_err_silent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && tone_error |-> pcm_sample == '0 && !clipped)
        else $error("tone_error with nonzero sample or clip");

    a_clip_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clipped |-> (pcm_sample == PCM_POS_FULL || pcm_sample == PCM_NEG_FULL))
        else $error("clipped sample not at full scale");

    a_clip_peaks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clipped |->
            peak_before_clamp >= PEAK_RAW_W'(ONE_Q14) && peak_after_clamp == ONE_Q14)
        else $error("clipped sample without full-scale peaks");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable(pcm_sample) && $stable(samples_total))
        else $error("stalled response changed");

endmodule

bind dds_tone_sample_generator_unit dts_checker u_dts_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .out_valid         (sample_rsp.valid),
    .out_ready         (sample_rsp.ready),
    .pcm_sample        (sample_rsp.pcm_sample),
    .clipped           (sample_rsp.clipped),
    .tone_error        (sample_rsp.tone_error),
    .peak_before_clamp (sample_rsp.peak_before_clamp),
    .peak_after_clamp  (sample_rsp.peak_after_clamp),
    .samples_total     (sample_rsp.samples_total)
);

`default_nettype wire

// ----- test/tb_dds_tone_sample_generator_unit.sv -----
`default_nettype none

module tb_dds_tone_sample_generator_unit import dts_pkg::*; ();

    localparam int        QUARTER    = 256;
    localparam longint    ONE_MAG    = 64'd1 << 45;
    localparam int        HOLD_LEN   = 200;
    localparam int        SEG_ITEMS  = 250;
    localparam int        NUM_SEGS   = 6;
    localparam int        NUM_ROWS   = 20;

    typedef struct packed {
        logic [TW_W-1:0]    tw;
        logic [LEVEL_W-1:0] level;
        logic               restart;
        logic               clear_metrics;
    } tone_req_t;

    typedef struct packed {
        logic [PCM_W-1:0]        pcm;
        logic                    clipped;
        logic                    tone_error;
        logic [PEAK_RAW_W-1:0]   peak_raw;
        logic [PEAK_CLAMP_W-1:0] peak_clamp;
        logic [OUT_COUNT_W-1:0]  clip_total;
        logic [OUT_COUNT_W-1:0]  sample_total;
    } tone_result_t;

    typedef struct packed {
        tone_req_t    req;
        logic         typed;
        tone_result_t res;
    } tone_row_t;

    logic clk;
    logic rst_n;

    dts_cfg_if cfg_if ();
    dts_in_if  req_if ();
    dts_out_if rsp_if ();

    dds_tone_sample_generator_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_if),
        .sample_req (req_if),
        .sample_rsp (rsp_if)
    );

    logic [15:0]        sine_quarter [0:QUARTER];
    logic [HEAD_W-1:0]  osc_headroom;
    logic [31:0]        osc_phase;
    logic [15:0]        osc_peak_raw;
    logic [14:0]        osc_peak_clamp;
    logic [47:0]        osc_clip_count;
    logic [47:0]        osc_sample_count;

    tone_result_t pending_samples [$];
    tone_row_t    tone_rows [NUM_ROWS];
    int           mismatch_count;
    int           req_idle_pct;
    int           rsp_stall_pct;
    bit           hold_request;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("dds_tone_sample_generator_unit test failed");
        $finish;
    end

    function automatic logic [15:0] quarter_sine(int unsigned k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned r;
        longint          sum;
        x    = (64'd1686629713 * k + QUARTER / 2) / QUARTER;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 8; n++)
        begin
            term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        r = (longint'(sum) + 64'd16384) >> 15;
        if (r > 64'd32768)
            r = 64'd32768;
        return r[15:0];
    endfunction

    function automatic void clear_tone_metrics();
        osc_peak_raw     = '0;
        osc_peak_clamp   = '0;
        osc_clip_count   = '0;
        osc_sample_count = '0;
    endfunction

    function automatic tone_result_t predict_tone_sample(tone_req_t r);
        longint unsigned m;
        longint unsigned mc;
        longint unsigned pr;
        longint unsigned pc;
        longint unsigned mag;
        logic [9:0]      idx;
        logic [1:0]      quad;
        logic [7:0]      i;
        logic [15:0]     ms;
        tone_result_t    res;
        res = '0;
        if (r.restart)
        begin
            osc_phase = '0;
            clear_tone_metrics();
        end
        if (r.clear_metrics)
            clear_tone_metrics();
        if (r.tw == '0)
            res.tone_error = 1'b1;
        else
        begin
            idx  = osc_phase[31:22];
            quad = idx[9:8];
            i    = idx[7:0];
            ms   = quad[0] ? sine_quarter[QUARTER - int'(i)] : sine_quarter[i];
            m    = 64'(osc_headroom) * 64'(r.level) * 64'(ms);
            mc   = (m > ONE_MAG) ? ONE_MAG : m;
            pr   = (m + (64'd1 << 30)) >> 31;
            pc   = (mc + (64'd1 << 30)) >> 31;
            osc_phase = osc_phase + 32'(r.tw);
            if (pr > 64'd65535)
                pr = 64'd65535;
            if (pr > 64'(osc_peak_raw))
                osc_peak_raw = pr[15:0];
            if (pc > 64'(osc_peak_clamp))
                osc_peak_clamp = pc[14:0];
            if (m > ONE_MAG)
            begin
                res.clipped = 1'b1;
                if (osc_clip_count != '1)
                    osc_clip_count = osc_clip_count + 1'b1;
            end
            if (osc_sample_count != '1)
                osc_sample_count = osc_sample_count + 1'b1;
            if (m >= ONE_MAG)
                res.pcm = quad[1] ? PCM_NEG_FULL : PCM_POS_FULL;
            else
            begin
                mag     = (m * 64'd32767 + (ONE_MAG >> 1)) >> 45;
                res.pcm = quad[1] ? 16'(64'd0 - mag) : mag[15:0];
            end
        end
        res.peak_raw     = osc_peak_raw;
        res.peak_clamp   = osc_peak_clamp;
        res.clip_total   = osc_clip_count;
        res.sample_total = osc_sample_count;
        return res;
    endfunction

    function automatic tone_req_t random_tone();
        tone_req_t r;
        int        pick;
        pick = $urandom_range(99);
        if (pick < 10)
            r.tw = '0;
        else if (pick < 20)
            r.tw = TW_W'($urandom_range(255, 1));
        else if (pick < 30)
            r.tw = '1 - TW_W'($urandom_range(255));
        else
            r.tw = TW_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 20)
            r.level = 16'd16384;
        else if (pick < 30)
            r.level = '1;
        else if (pick < 40)
            r.level = '0;
        else
            r.level = LEVEL_W'($urandom);
        r.restart       = ($urandom_range(99) < 3);
        r.clear_metrics = ($urandom_range(99) < 5);
        return r;
    endfunction

    function automatic string tone_text(tone_result_t r);
        return $sformatf("pcm=%0d clip=%0b err=%0b peak_raw=%0d peak_clamp=%0d clips=%0d samples=%0d",
                         $signed(r.pcm), r.clipped, r.tone_error, r.peak_raw, r.peak_clamp,
                         r.clip_total, r.sample_total);
    endfunction

    task automatic offer_tone(tone_req_t r, logic typed, tone_result_t typed_res);
        tone_result_t want;
        while ($urandom_range(99) < req_idle_pct)
        begin
            req_if.valid = 1'b0;
            @(negedge clk);
        end
        req_if.valid         = 1'b1;
        req_if.tuning_word   = r.tw;
        req_if.level         = r.level;
        req_if.restart       = r.restart;
        req_if.clear_metrics = r.clear_metrics;
        do
            @(posedge clk);
        while (!req_if.ready);
        want = predict_tone_sample(r);
        pending_samples.push_back(typed ? typed_res : want);
        @(negedge clk);
    endtask

    task automatic wait_tones_done();
        req_if.valid = 1'b0;
        while (pending_samples.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_headroom(logic [HEAD_W-1:0] value);
        wait_tones_done();
        cfg_if.valid = 1'b1;
        cfg_if.data  = value;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        osc_headroom = value;
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        rsp_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                rsp_if.ready = 1'b0;
                repeat (HOLD_LEN - 1) @(negedge clk);
                hold_request = 1'b0;
            end
            else
                rsp_if.ready = ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    always @(posedge clk)
    begin : check_samples
        tone_result_t seen;
        tone_result_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            seen.pcm          = rsp_if.pcm_sample;
            seen.clipped      = rsp_if.clipped;
            seen.tone_error   = rsp_if.tone_error;
            seen.peak_raw     = rsp_if.peak_before_clamp;
            seen.peak_clamp   = rsp_if.peak_after_clamp;
            seen.clip_total   = rsp_if.clipped_total;
            seen.sample_total = rsp_if.samples_total;
            if (pending_samples.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected sample transaction: %s", tone_text(seen));
            end
            else
            begin
                want = pending_samples.pop_front();
                if (seen !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("sample mismatch\n  expected %s\n  actual   %s",
                                 tone_text(want), tone_text(seen));
                end
            end
        end
    end

    initial
    begin
        logic [HEAD_W-1:0] headroom_pick;
        for (int k = 0; k <= QUARTER; k++)
            sine_quarter[k] = quarter_sine(k);
        rst_n                = 1'b0;
        req_if.valid         = 1'b0;
        req_if.tuning_word   = '0;
        req_if.level         = '0;
        req_if.restart       = 1'b0;
        req_if.clear_metrics = 1'b0;
        cfg_if.valid         = 1'b0;
        cfg_if.data          = '0;
        hold_request         = 1'b0;
        mismatch_count       = 0;
        osc_headroom         = HEADROOM_RESET;
        osc_phase            = '0;
        clear_tone_metrics();
        req_idle_pct  = 25;
        rsp_stall_pct = 60;

        // quarter-turn steps walk the table ends: 0, +1, 0, -1
        tone_rows = '{
            '{'{31'h0,        16'd16384, 1'b0, 1'b0}, 1'b1, '{16'h0000, 0, 1, 0,     0,     0, 0}},
            '{'{31'h40000000, 16'd16384, 1'b0, 1'b0}, 1'b1, '{16'h0000, 0, 0, 0,     0,     0, 1}},
            '{'{31'h40000000, 16'd16384, 1'b0, 1'b0}, 1'b1, '{16'h7FFF, 0, 0, 16384, 16384, 0, 2}},
            '{'{31'h40000000, 16'd16384, 1'b0, 1'b0}, 1'b1, '{16'h0000, 0, 0, 16384, 16384, 0, 3}},
            '{'{31'h40000000, 16'd16384, 1'b0, 1'b0}, 1'b1, '{16'h8000, 0, 0, 16384, 16384, 0, 4}},
            '{'{31'h40000000, 16'hFFFF,  1'b1, 1'b0}, 1'b1, '{16'h0000, 0, 0, 0,     0,     0, 1}},
            '{'{31'h40000000, 16'hFFFF,  1'b0, 1'b0}, 1'b1, '{16'h7FFF, 1, 0, 65535, 16384, 1, 2}},
            '{'{31'h0,        16'hFFFF,  1'b0, 1'b1}, 1'b1, '{16'h0000, 0, 1, 0,     0,     0, 0}},
            '{'{31'h0,        16'hFFFF,  1'b1, 1'b0}, 1'b1, '{16'h0000, 0, 1, 0,     0,     0, 0}},
            '{'{31'h7FFFFFFF, 16'h0000,  1'b0, 1'b0}, 1'b1, '{16'h0000, 0, 0, 0,     0,     0, 1}},
            '{'{31'h7FFFFFFF, 16'hFFFF,  1'b0, 1'b0}, 1'b0, '0},
            '{'{31'h7FFFFFFF, 16'hFFFF,  1'b0, 1'b0}, 1'b0, '0},
            '{'{31'h00000001, 16'h5555,  1'b0, 1'b0}, 1'b0, '0},
            '{'{31'h2AAAAAAA, 16'hAAAA,  1'b0, 1'b0}, 1'b0, '0},
            '{'{31'h55555555, 16'd16384, 1'b1, 1'b1}, 1'b0, '0},
            '{'{31'h12345678, 16'd20000, 1'b0, 1'b1}, 1'b0, '0},
            '{'{31'h40000000, 16'd16385, 1'b0, 1'b0}, 1'b0, '0},
            '{'{31'h0FFFFFFF, 16'd8192,  1'b0, 1'b0}, 1'b0, '0},
            '{'{31'h60000000, 16'd32768, 1'b0, 1'b0}, 1'b0, '0},
            '{'{31'h3FFFFFFF, 16'd1,     1'b0, 1'b0}, 1'b0, '0}
        };

        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        foreach (tone_rows[r])
            offer_tone(tone_rows[r].req, tone_rows[r].typed, tone_rows[r].res);

        for (int seg = 0; seg < NUM_SEGS; seg++)
        begin
            if (seg == 2)
            begin
                req_idle_pct  = 60;
                rsp_stall_pct = 25;
            end
            else if (seg == 4)
            begin
                req_idle_pct  = 0;
                rsp_stall_pct = 0;
            end
            case (seg)
                0:       headroom_pick = '1;
                1:       headroom_pick = '0;
                2:       headroom_pick = HEAD_W'(1);
                3:       headroom_pick = HEADROOM_RESET;
                4:       headroom_pick = HEAD_W'($urandom_range(65535, 32768));
                default: headroom_pick = HEAD_W'($urandom_range(131071, 1));
            endcase
            write_headroom(headroom_pick);
            for (int n = 0; n < SEG_ITEMS; n++)
            begin
                if (seg == 0 && n == 100)
                    hold_request = 1'b1;
                if (seg == 3 && n == 125)
                    wait_tones_done();
                offer_tone(random_tone(), 1'b0, '0);
            end
        end

        wait_tones_done();
        repeat (20) @(negedge clk);
        if (mismatch_count == 0)
            $display("dds_tone_sample_generator_unit test passed");
        else
            $display("dds_tone_sample_generator_unit test failed");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
hw/rtl/dts_pkg.sv
hw/rtl/dts_ifs.sv
hw/rtl/dts_front.sv
hw/rtl/dts_queue.sv
hw/rtl/dts_back.sv
hw/rtl/dds_tone_sample_generator_unit.sv
hw/rtl/dts_checker.sv
test/tb_dds_tone_sample_generator_unit.sv
